// File: rtl/core/planar_fluence_spectrum_histogram_core_defines.svh
// Assertion macros for the planar fluence spectrum histogram core.
// Included by files that check their own logic; no other dependencies.
`ifndef PLANAR_FLUENCE_SPECTRUM_HISTOGRAM_CORE_DEFINES_SVH
`define PLANAR_FLUENCE_SPECTRUM_HISTOGRAM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on clk, skipped while rst is high
`define PFSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on clk at every edge, reset included
`define PFSH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFSH_ASSERT(lbl, prop, msg)
`define PFSH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/pfsh_pkg.sv
// Shared types, codes and helpers of the planar fluence spectrum histogram core.
// No dependencies.
package pfsh_pkg;

  // Function codes of an input item
  localparam logic [1:0] FUNC_SCORE      = 2'd0;
  localparam logic [1:0] FUNC_READ_MAP   = 2'd1;
  localparam logic [1:0] FUNC_READ_SPEC  = 2'd2;
  localparam logic [1:0] FUNC_READ_TOTAL = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_PIXEL_WIDTH  = 2'd0;
  localparam logic [1:0] REG_PIXEL_HEIGHT = 2'd1;
  localparam logic [1:0] REG_EBIN_WIDTH   = 2'd2;

  localparam logic [30:0] PIXEL_RESET = 31'd65536;
  localparam logic [23:0] EBIN_RESET  = 24'd65536;

  localparam logic signed [31:0] DIR_LIMIT     = 32'sh4000_0000;
  localparam logic signed [31:0] DIR_LIMIT_NEG = 32'shC000_0000;
  localparam logic [63:0]        POS_LIMIT     = 64'h1000_0000_0000_0000;

  typedef struct packed {
    logic [1:0]         func;
    logic               is_photon;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [23:0]        energy;
    logic [23:0]        weight;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } item_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic        map_hit;
    logic        spectrum_hit;
  } result_t;

  // Clamp a direction cosine to [-1, 1] in Q2.30
  function automatic logic signed [31:0] clamp_dir(logic signed [31:0] v);
    if (v > DIR_LIMIT) return DIR_LIMIT;
    if (v < DIR_LIMIT_NEG) return DIR_LIMIT_NEG;
    return v;
  endfunction

  // Add and stick at all ones on overflow
  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

// File: rtl/core/pfsh_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
// Payload type is set at instantiation; no other dependencies.
interface pfsh_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/pfsh_mul.sv
// Shared registered 32x32 signed multiplier of the histogram core.
// No dependencies.
module pfsh_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/core/pfsh_div.sv
// Shared bit-serial restoring divider, one quotient bit per cycle.
// No dependencies.
module pfsh_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [6:0]  nb,
  input  logic [63:0] dvd,
  input  logic [63:0] dvs,
  output logic [63:0] quo,
  output logic        done
);

  logic        busy;
  logic [6:0]  cnt;
  logic [63:0] rem;
  logic [63:0] dvs_r;
  logic [63:0] trial;
  logic        ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem[62:0], quo[63]};
    ge    = (trial >= dvs_r);
  end

  // Count steps and flag completion
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= nb;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Hold remainder and quotient; align the dividend to the top on start
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= dvd << (7'd64 - nb);
      dvs_r <= dvs;
    end else if (busy) begin
      rem <= ge ? (trial - dvs_r) : trial;
      quo <= {quo[62:0], ge};
    end
  end

endmodule

// File: rtl/core/planar_fluence_spectrum_histogram_core.sv
// Planar photon fluence map and energy spectrum with saturating accumulators.
// A scored photon that hits the map makes four 63-bit passes and one 24-bit
// pass through the shared divider.
// One item at a time; the next item is taken while a result waits at the output.
// Synchronous reset, then a clearing pass over max(MAP_COLS*MAP_ROWS, ENERGY_BINS)
// addresses zeroes both stores before the first item is taken.
// Depends on pfsh_pkg, pfsh_stream_if, pfsh_mul, pfsh_div and the defines header.
`include "planar_fluence_spectrum_histogram_core_defines.svh"
module planar_fluence_spectrum_histogram_core #(
  parameter int MAP_COLS    = 64,
  parameter int MAP_ROWS    = 64,
  parameter int ENERGY_BINS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [30:0] wr_data,
  pfsh_stream_if.sink   in_ch,
  pfsh_stream_if.source out_ch
);
  import pfsh_pkg::*;

  localparam int MAP_DEPTH = MAP_COLS * MAP_ROWS;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SPEC_AW   = (ENERGY_BINS > 1) ? $clog2(ENERGY_BINS) : 1;
  localparam int CLR_DEPTH = (MAP_DEPTH > ENERGY_BINS) ? MAP_DEPTH : ENERGY_BINS;
  localparam int CW        = $clog2(CLR_DEPTH + 1);

  localparam logic [4:0] ST_CLEAR   = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_RDWAIT  = 5'd2;
  localparam logic [4:0] ST_RDDONE  = 5'd3;
  localparam logic [4:0] ST_MUL0    = 5'd4;
  localparam logic [4:0] ST_MUL1    = 5'd5;
  localparam logic [4:0] ST_MUL2    = 5'd6;
  localparam logic [4:0] ST_MUL3    = 5'd7;
  localparam logic [4:0] ST_MUL4    = 5'd8;
  localparam logic [4:0] ST_MUL5    = 5'd9;
  localparam logic [4:0] ST_DIVGO   = 5'd10;
  localparam logic [4:0] ST_DIVWAIT = 5'd11;
  localparam logic [4:0] ST_MAPRD   = 5'd12;
  localparam logic [4:0] ST_MAPWR   = 5'd13;
  localparam logic [4:0] ST_SPECRD  = 5'd14;
  localparam logic [4:0] ST_SPECWR  = 5'd15;
  localparam logic [4:0] ST_FINISH  = 5'd16;

  localparam logic [2:0] PH_PX = 3'd0;
  localparam logic [2:0] PH_CX = 3'd1;
  localparam logic [2:0] PH_PY = 3'd2;
  localparam logic [2:0] PH_CY = 3'd3;
  localparam logic [2:0] PH_EB = 3'd4;

  localparam logic [6:0] NB_POS = 7'd63;
  localparam logic [6:0] NB_EN  = 7'd24;

  logic [4:0]  state;
  logic [2:0]  phase;
  logic [CW-1:0] clr_cnt;
  logic [30:0] pixel_width;
  logic [30:0] pixel_height;
  logic [23:0] ebin_width;
  logic [63:0] total;

  item_t              itm;
  logic signed [31:0] dxc, dyc, dzc;
  logic [47:0]        edep;
  logic signed [63:0] prod_a, nx, ny;
  logic [7:0]         ix;
  logic [63:0]        dvd, dvs;
  logic [6:0]         nb;
  logic [MAP_AW-1:0]  map_addr;
  logic [SPEC_AW-1:0] spec_addr;
  logic               map_hit, spec_hit;
  logic [63:0]        res_value;
  logic               out_valid;
  result_t            out_data;

  // Shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic               div_start, div_done;
  logic [63:0]        div_quo;

  pfsh_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  pfsh_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .nb(nb), .dvd(dvd), .dvs(dvs),
    .quo(div_quo), .done(div_done)
  );

  // Memories
  logic [63:0] map_mem [MAP_DEPTH];
  logic [63:0] spec_mem [ENERGY_BINS];
  logic [63:0] map_rd, spec_rd;
  logic        map_we, spec_we;
  logic [MAP_AW-1:0]  map_waddr;
  logic [SPEC_AW-1:0] spec_waddr;
  logic [63:0] map_wdata, spec_wdata;

  // Derived widths and projection terms
  logic [30:0] wx, wy;
  logic [23:0] ew;
  logic [63:0] hx, hy, w2x, w2y;
  logic [31:0] dz_mag;
  logic [63:0] nx_mag, ny_mag;
  logic [63:0] q_clamp, px_s, d2;
  logic        neg;
  logic        is_y;

  always_comb begin
    wx     = (pixel_width == '0) ? 31'd1 : pixel_width;
    wy     = (pixel_height == '0) ? 31'd1 : pixel_height;
    ew     = (ebin_width == '0) ? 24'd1 : ebin_width;
    hx     = 64'(MAP_COLS) * {33'b0, wx};
    hy     = 64'(MAP_ROWS) * {33'b0, wy};
    w2x    = {32'b0, wx, 1'b0};
    w2y    = {32'b0, wy, 1'b0};
    dz_mag = dzc[31] ? 32'(-dzc) : 32'(dzc);
    nx_mag = nx[63] ? 64'(-nx) : 64'(nx);
    ny_mag = ny[63] ? 64'(-ny) : 64'(ny);
    is_y   = (phase == PH_PY);
    neg    = (is_y ? ny[63] : nx[63]) ^ dzc[31];
    q_clamp = (div_quo > POS_LIMIT) ? POS_LIMIT : div_quo;
    px_s   = neg ? (~q_clamp + 64'd1) : q_clamp;
    d2     = {px_s[62:0], 1'b0} + (is_y ? hy : hx);
  end

  // Feed the multiplier per sequencer step
  always_comb begin
    mul_a = itm.pos_x;
    mul_b = dzc;
    case (state)
      ST_MUL0: begin
        mul_a = $signed({8'b0, itm.energy});
        mul_b = $signed({8'b0, itm.weight});
      end
      ST_MUL1: begin
        mul_a = itm.pos_x;
        mul_b = dzc;
      end
      ST_MUL2: begin
        mul_a = dxc;
        mul_b = itm.pos_z;
      end
      ST_MUL3: begin
        mul_a = itm.pos_y;
        mul_b = dzc;
      end
      ST_MUL4: begin
        mul_a = dyc;
        mul_b = itm.pos_z;
      end
      default: begin
        mul_a = itm.pos_x;
        mul_b = dzc;
      end
    endcase
  end

  assign div_start = (state == ST_DIVGO);

  // Memory write selection: clearing pass or accumulate
  always_comb begin
    map_we     = ((state == ST_CLEAR) && (clr_cnt < CW'(MAP_DEPTH))) || (state == ST_MAPWR);
    spec_we    = ((state == ST_CLEAR) && (clr_cnt < CW'(ENERGY_BINS))) ||
                 (state == ST_SPECWR);
    map_waddr  = (state == ST_CLEAR) ? clr_cnt[MAP_AW-1:0] : map_addr;
    spec_waddr = (state == ST_CLEAR) ? clr_cnt[SPEC_AW-1:0] : spec_addr;
    map_wdata  = (state == ST_CLEAR) ? 64'd0 : sat_add(map_rd, {16'b0, edep});
    spec_wdata = (state == ST_CLEAR) ? 64'd0 : sat_add(spec_rd, {16'b0, edep});
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    map_rd <= map_mem[map_addr];
  end

  always_ff @(posedge clk) begin
    if (spec_we) spec_mem[spec_waddr] <= spec_wdata;
    spec_rd <= spec_mem[spec_addr];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_width  <= PIXEL_RESET;
      pixel_height <= PIXEL_RESET;
      ebin_width   <= EBIN_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_PIXEL_WIDTH:  pixel_width  <= wr_data;
        REG_PIXEL_HEIGHT: pixel_height <= wr_data;
        REG_EBIN_WIDTH:   ebin_width   <= wr_data[23:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready  = (state == ST_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      phase     <= PH_PX;
      clr_cnt   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      // Drop the result once transferred, unless a new one is loaded below
      if (out_valid && out_ch.ready && (state != ST_FINISH)) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + CW'(1);
          if (clr_cnt == CW'(CLR_DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_ch.valid) begin
            itm       <= in_ch.data;
            dxc       <= clamp_dir(in_ch.data.dir_x);
            dyc       <= clamp_dir(in_ch.data.dir_y);
            dzc       <= clamp_dir(in_ch.data.dir_z);
            map_hit   <= 1'b0;
            spec_hit  <= 1'b0;
            case (in_ch.data.func)
              FUNC_READ_MAP: begin
                res_value <= '0;
                map_addr <= MAP_AW'(17'(in_ch.data.read_row) * 17'(MAP_COLS) +
                                    17'(in_ch.data.read_col));
                if (({1'b0, in_ch.data.read_col} < 9'(MAP_COLS)) &&
                    ({1'b0, in_ch.data.read_row} < 9'(MAP_ROWS)))
                  state <= ST_RDWAIT;
                else
                  state <= ST_FINISH;
              end
              FUNC_READ_SPEC: begin
                res_value <= '0;
                spec_addr <= SPEC_AW'(in_ch.data.read_col);
                if ({1'b0, in_ch.data.read_col} < 9'(ENERGY_BINS)) state <= ST_RDWAIT;
                else state <= ST_FINISH;
              end
              FUNC_READ_TOTAL: begin
                res_value <= total;
                state     <= ST_FINISH;
              end
              default: begin
                res_value <= '0;
                state     <= in_ch.data.is_photon ? ST_MUL0 : ST_FINISH;
              end
            endcase
          end
        end
        ST_RDWAIT: state <= ST_RDDONE;
        ST_RDDONE: begin
          res_value <= (itm.func == FUNC_READ_MAP) ? map_rd : spec_rd;
          state     <= ST_FINISH;
        end
        ST_MUL0: state <= ST_MUL1;
        ST_MUL1: begin
          edep  <= prod[47:0];
          total <= sat_add(total, {16'b0, prod[47:0]});
          state <= (dzc == '0) ? ST_FINISH : ST_MUL2;
        end
        ST_MUL2: begin
          prod_a <= prod;
          state  <= ST_MUL3;
        end
        ST_MUL3: begin
          nx    <= prod_a - prod;
          state <= ST_MUL4;
        end
        ST_MUL4: begin
          prod_a <= prod;
          state  <= ST_MUL5;
        end
        ST_MUL5: begin
          ny    <= prod_a - prod;
          dvd   <= nx_mag;
          dvs   <= {32'b0, dz_mag};
          nb    <= NB_POS;
          phase <= PH_PX;
          state <= ST_DIVGO;
        end
        ST_DIVGO: state <= ST_DIVWAIT;
        ST_DIVWAIT: begin
          if (div_done) begin
            case (phase)
              PH_PX, PH_PY: begin
                if (d2[63]) begin
                  state <= ST_FINISH;
                end else begin
                  dvd   <= d2;
                  dvs   <= is_y ? w2y : w2x;
                  nb    <= NB_POS;
                  phase <= is_y ? PH_CY : PH_CX;
                  state <= ST_DIVGO;
                end
              end
              PH_CX: begin
                if (div_quo >= 64'(MAP_COLS)) begin
                  state <= ST_FINISH;
                end else begin
                  ix    <= div_quo[7:0];
                  dvd   <= ny_mag;
                  dvs   <= {32'b0, dz_mag};
                  nb    <= NB_POS;
                  phase <= PH_PY;
                  state <= ST_DIVGO;
                end
              end
              PH_CY: begin
                if (div_quo >= 64'(MAP_ROWS)) begin
                  state <= ST_FINISH;
                end else begin
                  map_addr <= MAP_AW'(17'(div_quo[7:0]) * 17'(MAP_COLS) + 17'(ix));
                  state    <= ST_MAPRD;
                end
              end
              default: begin
                if (div_quo >= 64'(ENERGY_BINS)) begin
                  state <= ST_FINISH;
                end else begin
                  spec_addr <= SPEC_AW'(div_quo[7:0]);
                  state     <= ST_SPECRD;
                end
              end
            endcase
          end
        end
        ST_MAPRD: state <= ST_MAPWR;
        ST_MAPWR: begin
          map_hit <= 1'b1;
          dvd     <= {40'b0, itm.energy};
          dvs     <= {40'b0, ew};
          nb      <= NB_EN;
          phase   <= PH_EB;
          state   <= ST_DIVGO;
        end
        ST_SPECRD: state <= ST_SPECWR;
        ST_SPECWR: begin
          spec_hit <= 1'b1;
          state    <= ST_FINISH;
        end
        ST_FINISH: begin
          // Load the output register once it is free
          if (!out_valid || out_ch.ready) begin
            out_valid             <= 1'b1;
            out_data.read_value   <= res_value;
            out_data.map_hit      <= map_hit;
            out_data.spectrum_hit <= spec_hit;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `PFSH_ASSERT(a_accept_drops_ready, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "ready after transfer")
  `PFSH_ASSERT(a_div_done_in_wait, div_done |-> (state == ST_DIVWAIT), "divider done out of step")
  `PFSH_ASSERT(a_spec_needs_map, out_valid |-> (out_data.map_hit || !out_data.spectrum_hit), "spectrum hit without map hit")
  `PFSH_ASSERT_ALWAYS(a_no_store_write_idle, (state == ST_IDLE) |-> !(map_we || spec_we), "store write while idle")

endmodule
